@@ hw/rtl/setab_pkg.sv @@
// Package for the sparse eligibility trace table.
// Holds sizes, command codes, payload structs and fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps

package setab_pkg;

  localparam int unsigned IndexW = 12;
  localparam int unsigned TraceW = 16;
  localparam int unsigned WeightW = 32;
  localparam int unsigned CountW = 9;
  localparam int unsigned SlotW = 8;

  // Table sizes; the field widths above are sized to match them.
  localparam int unsigned MemEntries = 4096;
  localparam int unsigned MaxActive = 256;

  localparam logic [TraceW-1:0] TraceOne = 16'd32768;
  localparam logic [TraceW-1:0] MinStartReset = 16'd328;
  localparam logic [10:0] GrowMul = 11'd1126;

  typedef enum logic [2:0] {
    CmdSet    = 3'd0,
    CmdClear  = 3'd1,
    CmdDecay  = 3'd2,
    CmdUpdate = 3'd3,
    CmdRead   = 3'd4,
    CmdWrite  = 3'd5,
    CmdRsvd6  = 3'd6,
    CmdRsvd7  = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]               command;
    logic [IndexW-1:0]        index;
    logic [TraceW-1:0]        fade_factor;
    logic signed [WeightW-1:0] scaled_step;
    logic signed [WeightW-1:0] weight_value;
  } cmd_t;

  typedef struct packed {
    logic signed [WeightW-1:0] weight_out;
    logic [CountW-1:0]         active_count;
    logic [TraceW-1:0]         min_trace_now;
  } rsp_t;

endpackage

@@ hw/rtl/sparse_eligibility_trace_table.sv @@
// From an accepted start each command reads its entry, dispatches and ends in the result
// strobe; an appending set also adds a list entry, and a clear that removes moves the last
// list entry into the freed slot. Decay walks every active entry and removes any that fall
// to zero or below the minimum; update walks every entry. A set on a full list grows the
// minimum and culls until there is room. A new item is taken from the strobe cycle on;
// results cannot stall. Reset clears weights and traces with busy high. Uses setab_*.
`timescale 1ns / 1ps

module sparse_eligibility_trace_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  setab_pkg::cmd_t cmd_i,
  output logic            done_o,
  output setab_pkg::rsp_t rsp_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [15:0]     cfg_data_i
);
  import setab_pkg::*;

  typedef enum logic [4:0] {
    StClear, StIdle, StRd, StDisp, StGrow,
    StWalkA, StWalkB, StWalkC, StWalkD,
    StDropA, StDropB, StDropC,
    StUpdA, StUpdB, StUpdC, StUpdD, StUpdE,
    StAppend, StFin, StDone
  } state_e;

  state_e state_q;
  cmd_t cmd_q;
  logic [IndexW-1:0] clr_q;
  logic [CountW-1:0] total_q;
  logic [CountW-1:0] slot_q;    // walk cursor; a decay or cull walk holds slot+1
  logic [TraceW-1:0] min_q;
  logic [IndexW-1:0] feat_q;    // feature under work in a walk
  logic [TraceW-1:0] trace_q;
  logic signed [47:0] prod_q;
  logic [SlotW-1:0] dslot_q;
  logic [IndexW-1:0] moved_q;
  logic done_q;
  rsp_t rsp_q;

  // Memory ports.
  logic w_we, t_we, l_we, p_we;
  logic [IndexW-1:0] w_addr, t_addr, p_addr;
  logic [SlotW-1:0] l_addr;
  logic [WeightW-1:0] w_wd, w_rd;
  logic [TraceW-1:0] t_wd, t_rd;
  logic [IndexW-1:0] l_wd, l_rd;
  logic [SlotW-1:0] p_wd, p_rd;

  setab_ram #(.Width(WeightW), .Depth(MemEntries)) u_weight (
    .clk_i(clk_i), .we_i(w_we), .addr_i(w_addr), .wdata_i(w_wd), .rdata_o(w_rd));
  setab_ram #(.Width(TraceW), .Depth(MemEntries)) u_trace (
    .clk_i(clk_i), .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wd), .rdata_o(t_rd));
  setab_ram #(.Width(IndexW), .Depth(MaxActive)) u_list (
    .clk_i(clk_i), .we_i(l_we), .addr_i(l_addr), .wdata_i(l_wd), .rdata_o(l_rd));
  setab_ram #(.Width(SlotW), .Depth(MemEntries)) u_pos (
    .clk_i(clk_i), .we_i(p_we), .addr_i(p_addr), .wdata_i(p_wd), .rdata_o(p_rd));

  logic [IndexW-1:0] fidx;
  logic is_set, is_clear, is_decay, is_write;
  assign fidx = cmd_q.index;
  assign is_set = (cmd_e'(cmd_q.command) == CmdSet);
  assign is_clear = (cmd_e'(cmd_q.command) == CmdClear);
  assign is_decay = (cmd_e'(cmd_q.command) == CmdDecay);
  assign is_write = (cmd_e'(cmd_q.command) == CmdWrite);

  // Shared multiplier: trace by rate for decay, step by trace for update.
  logic [TraceW-1:0] rate_sat;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic [TraceW-1:0] new_trace;
  assign rate_sat = (cmd_q.fade_factor > TraceOne) ? TraceOne : cmd_q.fade_factor;
  assign mul_a = is_decay ? $signed({17'd0, rate_sat})
                          : $signed({cmd_q.scaled_step[31], cmd_q.scaled_step});
  assign mul_b = $signed({1'b0, trace_q});
  assign mul_p = mul_a * mul_b;
  assign new_trace = mul_p[30:15];

  // Minimum growth with floor of +1 and saturation.
  logic [26:0] grow_raw;
  logic [16:0] grown;
  logic [TraceW-1:0] min_next;
  assign grow_raw = {11'd0, min_q} * {16'd0, GrowMul};
  always_comb begin
    grown = grow_raw[26:10] > 17'(min_q) ? grow_raw[26:10] : 17'(min_q) + 17'd1;
    min_next = (grown > 17'd65535) ? 16'hFFFF : grown[15:0];
  end

  // Arithmetic shift rounds toward minus infinity; the add saturates.
  logic signed [48:0] sum;
  logic signed [WeightW-1:0] sat;
  assign sum = 49'(signed'(w_rd)) + 49'(prod_q >>> 15);
  always_comb begin
    if (sum > 49'sd2147483647) sat = 32'sh7FFFFFFF;
    else if (sum < -49'sd2147483648) sat = 32'sh80000000;
    else sat = sum[31:0];
  end

  logic [CountW-1:0] tot_m1, slot_m1;
  assign tot_m1 = total_q - CountW'(1);
  assign slot_m1 = slot_q - CountW'(1);

  // Memory port control.
  always_comb begin
    w_we = 1'b0; t_we = 1'b0; l_we = 1'b0; p_we = 1'b0;
    w_addr = fidx; t_addr = fidx; p_addr = fidx;
    l_addr = dslot_q;
    w_wd = cmd_q.weight_value; t_wd = '0; l_wd = fidx; p_wd = total_q[SlotW-1:0];
    unique case (state_q)
      StClear: begin
        w_we = 1'b1; t_we = 1'b1; w_addr = clr_q; t_addr = clr_q; w_wd = '0;
      end
      StDisp: begin
        w_we = is_write;
        t_we = is_set && (t_rd != '0);
        t_wd = TraceOne;
      end
      StWalkA: l_addr = slot_m1[SlotW-1:0];
      StWalkB: t_addr = l_rd;
      StWalkD: begin
        t_addr = feat_q;
        if (is_decay) begin
          t_we = 1'b1; t_wd = new_trace;
        end
      end
      StDropA: begin
        t_we = 1'b1; t_addr = feat_q; t_wd = '0;
        l_addr = tot_m1[SlotW-1:0];
      end
      StDropB: begin
        l_we = 1'b1; l_addr = dslot_q; l_wd = l_rd;
      end
      StDropC: begin
        p_we = 1'b1; p_addr = moved_q; p_wd = dslot_q;
      end
      StUpdA: l_addr = slot_q[SlotW-1:0];
      StUpdB: begin
        t_addr = l_rd; w_addr = l_rd;
      end
      StUpdC, StUpdD: w_addr = feat_q;
      StUpdE: begin
        w_we = 1'b1; w_addr = feat_q; w_wd = sat;
      end
      StAppend: begin
        t_we = 1'b1; t_wd = TraceOne;
        l_we = 1'b1; l_addr = total_q[SlotW-1:0]; l_wd = fidx;
        p_we = 1'b1; p_wd = total_q[SlotW-1:0];
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cmd_q <= '0;
      clr_q <= '0;
      total_q <= '0;
      slot_q <= '0;
      min_q <= MinStartReset;
      feat_q <= '0;
      trace_q <= '0;
      prod_q <= '0;
      dslot_q <= '0;
      moved_q <= '0;
      done_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + IndexW'(1);
          if (clr_q == IndexW'(MemEntries - 1)) state_q <= StIdle;
        end
        StIdle: begin
          // A configuration write also reloads the running minimum.
          if (cfg_valid_i) min_q <= cfg_data_i;
          if (start) begin
            cmd_q <= cmd_i;
            state_q <= StRd;
          end
        end
        StRd: state_q <= StDisp;
        StDisp: begin
          unique case (cmd_e'(cmd_q.command))
            CmdSet: begin
              if (t_rd != '0) state_q <= StFin;
              else if (total_q >= CountW'(MaxActive)) state_q <= StGrow;
              else state_q <= StAppend;
            end
            CmdClear: begin
              if (t_rd != '0) begin
                feat_q <= fidx;
                dslot_q <= p_rd;
                state_q <= StDropA;
              end else state_q <= StFin;
            end
            CmdDecay: begin
              slot_q <= total_q;
              state_q <= StWalkA;
            end
            CmdUpdate: begin
              slot_q <= '0;
              state_q <= StUpdA;
            end
            default: state_q <= StFin;
          endcase
        end
        StGrow: begin
          min_q <= min_next;
          slot_q <= total_q;
          state_q <= StWalkA;
        end
        // Walk from the last slot down, for decay or for a cull after growth.
        StWalkA: begin
          if (slot_q == '0) begin
            if (is_set) begin
              state_q <= (total_q >= CountW'(MaxActive)) ? StGrow : StAppend;
            end else state_q <= StFin;
          end else state_q <= StWalkB;
        end
        StWalkB: begin
          feat_q <= l_rd;
          dslot_q <= slot_m1[SlotW-1:0];
          state_q <= StWalkC;
        end
        StWalkC: begin
          trace_q <= t_rd;
          state_q <= StWalkD;
        end
        StWalkD: begin
          slot_q <= slot_m1;
          if (is_set) begin
            state_q <= (trace_q < min_q) ? StDropA : StWalkA;
          end else begin
            state_q <= (new_trace == '0 || new_trace < min_q) ? StDropA : StWalkA;
          end
        end
        // Removal: the last list entry moves into the freed slot.
        StDropA: begin
          total_q <= tot_m1;
          state_q <= StDropB;
        end
        StDropB: begin
          moved_q <= l_rd;
          state_q <= StDropC;
        end
        StDropC: state_q <= is_clear ? StFin : StWalkA;
        // Weight update walks the list upward.
        StUpdA: state_q <= (slot_q == total_q) ? StFin : StUpdB;
        StUpdB: begin
          feat_q <= l_rd;
          state_q <= StUpdC;
        end
        StUpdC: begin
          trace_q <= t_rd;
          state_q <= StUpdD;
        end
        StUpdD: begin
          prod_q <= mul_p[47:0];
          state_q <= StUpdE;
        end
        StUpdE: begin
          slot_q <= slot_q + CountW'(1);
          state_q <= StUpdA;
        end
        StAppend: begin
          total_q <= total_q + CountW'(1);
          state_q <= StFin;
        end
        StFin: state_q <= StDone;
        StDone: begin
          done_q <= 1'b1;
          rsp_q.weight_out <= w_rd;
          rsp_q.active_count <= total_q;
          rsp_q.min_trace_now <= min_q;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  // Checks.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CountW'(MaxActive)) else $error("active count above capacity");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe longer than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == StIdle)) else $error("result strobe while busy");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !cfg_ready_o) else $error("config taken while busy");

endmodule

@@ hw/rtl/setab_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module setab_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle; read data is registered and comes in the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ verif/sparse_eligibility_trace_table_test.sv @@
// Self-checking testbench for the sparse eligibility trace table.
// Predicts every result from its own model of traces, weights and the active list.
// Depends on setab_pkg and the sparse_eligibility_trace_table RTL.
`timescale 1ns / 1ps

module sparse_eligibility_trace_table_test;
  import setab_pkg::*;

  localparam int unsigned Entries = 4096;
  localparam int unsigned ActiveMax = 256;
  localparam int unsigned PhaseItems = 140;
  localparam longint unsigned CycleLimit = 12000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  // Model state of the table.
  logic signed [31:0] weight_mem [Entries];
  logic [15:0] trace_mem [Entries];
  logic [11:0] slot_feature [ActiveMax];
  logic [7:0] feature_slot [Entries];
  int unsigned live_count;
  logic [15:0] min_level;

  rsp_t pending_rsp [$];
  int unsigned errors = 0;
  longint unsigned cycle_count = 0;

  sparse_eligibility_trace_table u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .cmd_i(cmd_i),
    .done_o(done_o),
    .rsp_o(rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Removes one list slot by moving the last entry into it.
  function automatic void drop_entry(int unsigned slot);
    logic [11:0] moved;
    trace_mem[slot_feature[slot]] = '0;
    live_count--;
    moved = slot_feature[live_count];
    slot_feature[slot] = moved;
    feature_slot[moved] = slot[7:0];
  endfunction

  // Grows the minimum by about 1.1 and culls every trace below it.
  function automatic void grow_minimum();
    int unsigned grown;
    grown = (int'(min_level) * int'(GrowMul)) >> 10;
    if (grown <= min_level) grown = min_level + 1;
    if (grown > 65535) grown = 65535;
    min_level = grown[15:0];
    for (int unsigned s = live_count; s > 0; s--) begin
      if (trace_mem[slot_feature[s-1]] < min_level) drop_entry(s - 1);
    end
  endfunction

  // Applies one command to the model and returns the result it produces.
  function automatic rsp_t apply_command(cmd_t c);
    rsp_t r;
    logic [11:0] f;
    int unsigned rate;
    int unsigned t;
    longint prod;
    longint sum;
    f = c.index;
    case (cmd_e'(c.command))
      CmdSet: begin
        if (trace_mem[f] != 0) begin
          trace_mem[f] = TraceOne;
        end else begin
          while (live_count >= ActiveMax) grow_minimum();
          trace_mem[f] = TraceOne;
          slot_feature[live_count] = f;
          feature_slot[f] = live_count[7:0];
          live_count++;
        end
      end
      CmdClear: begin
        if (trace_mem[f] != 0) drop_entry(feature_slot[f]);
      end
      CmdDecay: begin
        rate = (c.fade_factor > TraceOne) ? TraceOne : c.fade_factor;
        for (int unsigned s = live_count; s > 0; s--) begin
          t = (int'(trace_mem[slot_feature[s-1]]) * rate) >> 15;
          trace_mem[slot_feature[s-1]] = t[15:0];
          if (t == 0 || t < min_level) drop_entry(s - 1);
        end
      end
      CmdUpdate: begin
        for (int unsigned s = 0; s < live_count; s++) begin
          prod = longint'(c.scaled_step) * longint'(trace_mem[slot_feature[s]]);
          sum = longint'(weight_mem[slot_feature[s]]) + (prod >>> 15);
          if (sum > 64'sh7FFFFFFF) sum = 64'sh7FFFFFFF;
          if (sum < -64'sh80000000) sum = -64'sh80000000;
          weight_mem[slot_feature[s]] = sum[31:0];
        end
      end
      CmdWrite: weight_mem[f] = c.weight_value;
      default: ;
    endcase
    r.weight_out = weight_mem[f];
    r.active_count = live_count[8:0];
    r.min_trace_now = min_level;
    return r;
  endfunction

  // Compares each result strobe with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: got %h", $realtime, rsp_o);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.weight_out !== want.weight_out) begin
          $display("%0t weight_out: expected %h, got %h", $realtime, want.weight_out,
                   rsp_o.weight_out);
          errors++;
        end
        if (rsp_o.active_count !== want.active_count) begin
          $display("%0t active_count: expected %0d, got %0d", $realtime,
                   want.active_count, rsp_o.active_count);
          errors++;
        end
        if (rsp_o.min_trace_now !== want.min_trace_now) begin
          $display("%0t min_trace_now: expected %0d, got %0d", $realtime,
                   want.min_trace_now, rsp_o.min_trace_now);
          errors++;
        end
      end
    end
  end

  // Sends one command after a random gap; start stays high between back-to-back transfers.
  task automatic send_cmd(cmd_t c);
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    gap = (pick < 65) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_rsp.push_back(apply_command(c));
  endtask

  task automatic send_fields(cmd_e op, logic [11:0] idx, logic [15:0] rate,
                             logic [31:0] step, logic [31:0] value);
    cmd_t c;
    c.command = op;
    c.index = idx;
    c.fade_factor = rate;
    c.scaled_step = step;
    c.weight_value = value;
    send_cmd(c);
  endtask

  // Drops start, lets every expected result come back, then idles on before returning.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_min_start(logic [15:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    min_level = value;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c.command = (r < 45) ? CmdSet : (r < 55) ? CmdClear : (r < 62) ? CmdDecay :
                (r < 71) ? CmdUpdate : (r < 82) ? CmdRead : (r < 95) ? CmdWrite :
                (r < 97) ? CmdRsvd6 : CmdRsvd7;
    // A small pool of features keeps the list filling and culling.
    c.index = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 383) : $urandom();
    r = $urandom_range(0, 99);
    c.fade_factor = (r < 60) ? $urandom_range(29000, 32768) :
                    (r < 80) ? $urandom() : $urandom_range(0, 32768);
    c.scaled_step = ($urandom_range(0, 99) < 30) ? $urandom() :
                    $signed($urandom_range(0, 262144)) - 131072;
    c.weight_value = $urandom();
    return c;
  endfunction

  task automatic test_reset_state();
    send_fields(CmdRead, 12'd0, '0, '0, '0);
    send_fields(CmdRead, 12'hFFF, '0, '0, '0);
  endtask

  // Field extremes, every command and the named corner cases.
  task automatic test_directed();
    send_fields(CmdWrite, 12'd0, '0, '0, 32'h7FFFFFF0);
    send_fields(CmdWrite, 12'hFFF, '0, '0, 32'h80000010);
    send_fields(CmdSet, 12'd0, '0, '0, '0);
    send_fields(CmdSet, 12'hFFF, '0, '0, '0);
    send_fields(CmdSet, 12'd0, '0, '0, '0);
    send_fields(CmdUpdate, 12'd0, '0, 32'h7FFFFFFF, '0);
    send_fields(CmdUpdate, 12'hFFF, '0, 32'h80000000, '0);
    send_fields(CmdUpdate, 12'hFFF, '0, 32'hFFFFFFFF, '0);
    send_fields(CmdRead, 12'd0, '0, '0, '0);
    // A rate above one acts as exactly one.
    send_fields(CmdDecay, 12'd0, 16'hFFFF, '0, '0);
    send_fields(CmdDecay, 12'd0, 16'd16384, '0, '0);
    send_fields(CmdClear, 12'hFFF, '0, '0, '0);
    send_fields(CmdClear, 12'hFFF, '0, '0, '0);
    send_fields(CmdRsvd6, 12'd0, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_fields(CmdRsvd7, 12'hFFF, '0, '0, '0);
    send_fields(CmdSet, 12'd5, '0, '0, '0);
    send_fields(CmdDecay, 12'd0, 16'd0, '0, '0);
    send_fields(CmdRead, 12'd5, '0, '0, '0);
  endtask

  // A zero minimum, then a trace left below a raised minimum that set only rewrites.
  task automatic test_minimum_edges();
    write_min_start(16'd0);
    send_fields(CmdSet, 12'd7, '0, '0, '0);
    send_fields(CmdDecay, 12'd7, 16'd3, '0, '0);
    write_min_start(16'd32768);
    send_fields(CmdSet, 12'd7, '0, '0, '0);
    send_fields(CmdDecay, 12'd7, 16'd32767, '0, '0);
    write_min_start(16'd1);
  endtask

  task automatic test_random();
    logic [15:0] levels [6];
    levels = '{16'd0, 16'd32768, 16'd1, 16'd328, 16'hFFFF, 16'd328};
    levels[3] = $urandom_range(1, 32768);
    for (int p = 0; p < 6; p++) begin
      write_min_start(levels[p]);
      // Pause once with no gap requested until the block has drained.
      if (p == 2) wait_idle();
      for (int unsigned i = 0; i < PhaseItems; i++) send_cmd(random_cmd());
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < Entries; i++) begin
      weight_mem[i] = '0;
      trace_mem[i] = '0;
    end
    live_count = 0;
    min_level = MinStartReset;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed();
    test_minimum_edges();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/setab_pkg.sv
hw/rtl/setab_ram.sv
hw/rtl/sparse_eligibility_trace_table.sv
verif/sparse_eligibility_trace_table_test.sv
